// ===== src/dssb_pkg.sv =====
package dssb_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CNT_W = 7;
   localparam int VAL_W = 32;

   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_SHOW = 2'd2;
   localparam logic [1:0] OP_LEN  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVER  = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]              opcode;
      logic                    stack_select;
      logic signed [VAL_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] entry_value;
      logic [CNT_W-1:0]        length;
      logic                    last;
   } rsp_type;

   // Decoded request as it sits in the queue between front and back.
   typedef struct packed {
      logic                    is_push;
      logic                    is_pop;
      logic                    is_show;
      logic                    is_len;
      logic                    sel;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// ===== src/dssb_front.sv =====
module dssb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  dssb_pkg::req_type        req_payload,
   output dssb_pkg::queue_head_type head,
   input  logic                     take
);

   dssb_pkg::cmd_type ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   dssb_pkg::cmd_type dec;

   always_comb begin
      dec.is_push = 1'b0;
      dec.is_pop  = 1'b0;
      dec.is_show = 1'b0;
      dec.is_len  = 1'b0;
      unique case (req_payload.opcode)
         dssb_pkg::OP_PUSH: dec.is_push = 1'b1;
         dssb_pkg::OP_POP:  dec.is_pop  = 1'b1;
         dssb_pkg::OP_SHOW: dec.is_show = 1'b1;
         dssb_pkg::OP_LEN:  dec.is_len  = 1'b1;
         default:           dec.is_len  = 1'b1;
      endcase
      dec.sel   = req_payload.stack_select;
      dec.value = req_payload.push_value;
   end

   assign busy = (count_ff == 2'd2);
   assign push = start & ~busy;
   assign pop  = take & (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== src/dssb_back.sv =====
module dssb_back #(
   parameter int DEPTH = dssb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dssb_pkg::CNT_W-1:0]    capacity,
   input  dssb_pkg::queue_head_type      head,
   output logic                          take,
   output logic                          rsp_strobe,
   output dssb_pkg::rsp_type             rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = dssb_pkg::CNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic [dssb_pkg::VAL_W-1:0] mem_ff [DEPTH];

   logic                    state_ff, state_in;
   logic [CW-1:0]           cf_ff, cf_in;
   logic [CW-1:0]           cs_ff, cs_in;
   logic [CW-1:0]           k_ff, k_in;
   logic                    sel_ff, sel_in;
   logic [CW-1:0]           show_len_ff, show_len_in;
   logic                    res_valid_ff, res_valid_in;
   dssb_pkg::rsp_type       res_ff, res_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rd_last_ff;
   logic [dssb_pkg::VAL_W-1:0] rd_data_ff;

   logic [CW-1:0]           eff_cap;
   logic [CW:0]             fill;
   logic [CW-1:0]           cnt_sel;
   logic                    wr_en;
   logic [CW-1:0]           wr_pos;
   logic [CW-1:0]           rd_pos;
   logic                    rd_en;

   always_comb begin
      if (capacity == '0) begin
         eff_cap = CW'(1);
      end else if (capacity > DEPTH_C) begin
         eff_cap = DEPTH_C;
      end else begin
         eff_cap = capacity;
      end
   end

   assign fill    = {1'b0, cf_ff} + {1'b0, cs_ff};
   assign cnt_sel = head.cmd.sel ? cs_ff : cf_ff;
   assign take    = (state_ff == ST_IDLE) & head.valid;

   // Stack two lives at the bottom, stack one counts down from the top entry.
   assign wr_pos = head.cmd.sel ? cs_ff : (TOP_C - cf_ff);
   assign rd_pos = sel_ff ? k_ff : (TOP_C - k_ff);
   assign rd_en  = (state_ff == ST_SHOW);

   always_comb begin
      state_in     = state_ff;
      cf_in        = cf_ff;
      cs_in        = cs_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      show_len_in  = show_len_ff;
      res_valid_in = 1'b0;
      res_in       = res_ff;
      rd_valid_in  = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               res_in.entry_value = '0;
               res_in.last        = 1'b1;
               res_in.status      = dssb_pkg::ST_OK;
               res_in.length      = cnt_sel;
               if (head.cmd.is_push) begin
                  res_valid_in = 1'b1;
                  if (fill >= {1'b0, eff_cap}) begin
                     res_in.status = dssb_pkg::ST_OVER;
                  end else begin
                     wr_en         = 1'b1;
                     res_in.length = cnt_sel + CW'(1);
                     if (head.cmd.sel) begin
                        cs_in = cs_ff + CW'(1);
                     end else begin
                        cf_in = cf_ff + CW'(1);
                     end
                  end
               end else if (head.cmd.is_pop) begin
                  res_valid_in = 1'b1;
                  if (cnt_sel == '0) begin
                     res_in.status = dssb_pkg::ST_UNDER;
                  end else begin
                     res_in.length = cnt_sel - CW'(1);
                     if (head.cmd.sel) begin
                        cs_in = cs_ff - CW'(1);
                     end else begin
                        cf_in = cf_ff - CW'(1);
                     end
                  end
               end else if (head.cmd.is_show) begin
                  if (cnt_sel == '0) begin
                     res_valid_in  = 1'b1;
                     res_in.status = dssb_pkg::ST_EMPTY;
                  end else begin
                     state_in    = ST_SHOW;
                     k_in        = cnt_sel - CW'(1);
                     sel_in      = head.cmd.sel;
                     show_len_in = cnt_sel;
                  end
               end else begin
                  res_valid_in = 1'b1;
               end
            end
         end
         ST_SHOW: begin
            rd_valid_in = 1'b1;
            if (k_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff - CW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cf_ff        <= '0;
         cs_ff        <= '0;
         res_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cf_ff        <= cf_in;
         cs_ff        <= cs_in;
         res_valid_ff <= res_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      sel_ff      <= sel_in;
      show_len_ff <= show_len_in;
      res_ff      <= res_in;
      rd_last_ff  <= (k_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_pos[AW-1:0]] <= head.cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_pos[AW-1:0]];
      end
   end

   assign rsp_strobe = res_valid_ff | rd_valid_ff;

   always_comb begin
      if (rd_valid_ff) begin
         rsp_payload.status      = dssb_pkg::ST_OK;
         rsp_payload.entry_value = rd_data_ff;
         rsp_payload.length      = show_len_ff;
         rsp_payload.last        = rd_last_ff;
      end else begin
         rsp_payload = res_ff;
      end
   end

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(res_valid_ff && rd_valid_ff))
      else $error("immediate result and show entry collide");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cf_ff} + {1'b0, cs_ff}) <= {1'b0, DEPTH_C})
      else $error("stack counts exceed buffer depth");

   a_no_take_in_show: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> !take)
      else $error("request taken during show walk");

   a_show_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_last_ff) |-> $past(state_ff == ST_SHOW) && (state_ff == ST_IDLE))
      else $error("show walk did not end with its final entry");

endmodule

// ===== src/dual_stack_shared_buffer_core.sv =====
// Channel   | Ports                               | Handshake
// request   | start, busy, req_payload            | taken when start is high and busy low
// result    | rsp_strobe, rsp_payload             | one cycle per result, no back pressure
// register  | csr_we, csr_wdata                   | capacity written when csr_we is high
//
// Push, pop and length leave the execution unit idle, so one such request per cycle
// is sustained unless a show holds the unit; the request queue and then the result
// register lie between acceptance and result. A show of n entries holds the unit,
// reading one entry per cycle from the single-port entry memory; one result per entry.
// Reset clears both counts, the request queue and sets capacity to 64.
// Busy rises only when the two-entry request queue is full.
module dual_stack_shared_buffer_core #(
   parameter int DEPTH = dssb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dssb_pkg::req_type             req_payload,
   output logic                          rsp_strobe,
   output dssb_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [dssb_pkg::CNT_W-1:0]    csr_wdata
);

   logic [dssb_pkg::CNT_W-1:0] capacity_ff;
   dssb_pkg::queue_head_type   head;
   logic                       take;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= dssb_pkg::CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   dssb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .head        (head),
      .take        (take)
   );

   dssb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .head        (head),
      .take        (take),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH = dssb_pkg::DEPTH_DEFAULT;

   typedef struct {
      dssb_pkg::req_type req;
      bit                hold_until_drained;
   } pending_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   dssb_pkg::req_type           req_payload = '0;
   logic                        rsp_strobe;
   dssb_pkg::rsp_type           rsp_payload;
   logic                        csr_we = 1'b0;
   logic [dssb_pkg::CNT_W-1:0]  csr_wdata = '0;

   pending_type                 pending_requests[$];
   dssb_pkg::rsp_type           expected_results[$];
   logic                        results_drained = 1'b1;
   int                          sender_idle_pct = 0;

   // Local copy of the buffer, both counts and the capacity setting.
   logic [dssb_pkg::VAL_W-1:0]  shadow_store[DEPTH];
   logic [dssb_pkg::CNT_W-1:0]  used_first = '0;
   logic [dssb_pkg::CNT_W-1:0]  used_second = '0;
   logic [dssb_pkg::CNT_W-1:0]  capacity_setting = dssb_pkg::CAP_RESET;

   int                failures = 0;
   int                requests_taken = 0;
   int                results_checked = 0;
   int                overflows = 0;
   int                underflows = 0;
   int                empty_shows = 0;
   int                deepest_show = 0;

   dual_stack_shared_buffer_core #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int capacity_limit();
      if (capacity_setting == 0) return 1;
      if (int'(capacity_setting) > DEPTH) return DEPTH;
      return int'(capacity_setting);
   endfunction

   task automatic predict_stack_op(input dssb_pkg::req_type r);
      dssb_pkg::rsp_type          res;
      logic [dssb_pkg::CNT_W-1:0] cnt;
      int                         pos;
      int                         idx;
      cnt = r.stack_select ? used_second : used_first;
      res = '0;
      res.last = 1'b1;
      res.status = dssb_pkg::ST_OK;
      case (r.opcode)
         dssb_pkg::OP_PUSH: begin
            if (int'(used_first) + int'(used_second) >= capacity_limit()) begin
               res.status = dssb_pkg::ST_OVER;
               overflows++;
            end else begin
               idx = r.stack_select ? int'(cnt) : DEPTH - 1 - int'(cnt);
               shadow_store[idx] = r.push_value;
               cnt = cnt + dssb_pkg::CNT_W'(1);
            end
            res.length = cnt;
            expected_results.push_back(res);
         end
         dssb_pkg::OP_POP: begin
            if (cnt == 0) begin
               res.status = dssb_pkg::ST_UNDER;
               underflows++;
            end else begin
               cnt = cnt - dssb_pkg::CNT_W'(1);
            end
            res.length = cnt;
            expected_results.push_back(res);
         end
         dssb_pkg::OP_LEN: begin
            res.length = cnt;
            expected_results.push_back(res);
         end
         dssb_pkg::OP_SHOW: begin
            if (cnt == 0) begin
               res.status = dssb_pkg::ST_EMPTY;
               empty_shows++;
               expected_results.push_back(res);
            end else begin
               if (int'(cnt) > deepest_show) deepest_show = int'(cnt);
               // Top of the stack first; stack one is stored downward from the end.
               for (int i = 0; i < int'(cnt); i++) begin
                  pos = int'(cnt) - 1 - i;
                  idx = r.stack_select ? pos : DEPTH - 1 - pos;
                  res.entry_value = shadow_store[idx];
                  res.length = cnt;
                  res.last = (i == int'(cnt) - 1);
                  expected_results.push_back(res);
               end
            end
         end
      endcase
      if (r.stack_select) used_second = cnt;
      else used_first = cnt;
   endtask

   always @(posedge clock) begin : drive_requests
      logic taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            predict_stack_op(req_payload);
            void'(pending_requests.pop_front());
            requests_taken++;
         end
         if (!start || taken) begin
            if (pending_requests.size() == 0) begin
               start <= 1'b0;
            end else if (pending_requests[0].hold_until_drained &&
                         (taken || !results_drained)) begin
               start <= 1'b0;
            end else if ($urandom_range(99) < sender_idle_pct) begin
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_payload <= pending_requests[0].req;
            end
         end
      end
   end

   always @(negedge clock) begin
      results_drained <= (expected_results.size() == 0);
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : check_results
      dssb_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display({"%0t: unexpected result, expected none, ",
                      "actual status %0d value %0h length %0d last %0d"},
                     $time, rsp_payload.status, rsp_payload.entry_value,
                     rsp_payload.length, rsp_payload.last);
            failures++;
         end else begin
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_payload.status));
            compare_field("entry_value", want.entry_value, rsp_payload.entry_value);
            compare_field("length", 32'(want.length), 32'(rsp_payload.length));
            compare_field("last", 32'(want.last), 32'(rsp_payload.last));
            results_checked++;
         end
      end
   end

   task automatic add_request(input logic [1:0] opcode, input logic sel,
                              input logic [dssb_pkg::VAL_W-1:0] value, input bit hold);
      pending_type p;
      p.req.opcode = opcode;
      p.req.stack_select = sel;
      p.req.push_value = value;
      p.hold_until_drained = hold;
      pending_requests.push_back(p);
   endtask

   function automatic logic [dssb_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_requests(input int count, input int push_pct, input int pop_pct);
      int         roll;
      logic [1:0] opcode;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < push_pct) opcode = dssb_pkg::OP_PUSH;
         else if (roll < push_pct + pop_pct) opcode = dssb_pkg::OP_POP;
         else if ($urandom_range(2) == 0) opcode = dssb_pkg::OP_SHOW;
         else opcode = dssb_pkg::OP_LEN;
         add_request(opcode, 1'($urandom_range(1)), pick_value(), $urandom_range(49) == 0);
      end
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [dssb_pkg::CNT_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_setting = value;
      repeat (2) @(posedge clock);
   endtask

   initial begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 20;

      // Empty stacks first, then extremes of the value range in both stacks.
      add_request(dssb_pkg::OP_POP,  1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_POP,  1'b1, '1, 1'b0);
      add_request(dssb_pkg::OP_SHOW, 1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_SHOW, 1'b1, '0, 1'b0);
      add_request(dssb_pkg::OP_LEN,  1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b0, 32'h7fff_ffff, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b0, 32'h8000_0000, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b1, '0, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b1, '1, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b1, 32'h5a5a_a5a5, 1'b0);
      add_request(dssb_pkg::OP_SHOW, 1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_SHOW, 1'b1, '0, 1'b1);
      add_request(dssb_pkg::OP_LEN,  1'b1, '1, 1'b0);
      add_request(dssb_pkg::OP_POP,  1'b1, '0, 1'b0);
      add_request(dssb_pkg::OP_LEN,  1'b1, '0, 1'b0);
      wait_until_drained();

      // A zero capacity acts as one, and it now sits below the present fill.
      write_capacity('0);
      add_request(dssb_pkg::OP_PUSH, 1'b0, 32'h1234_5678, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b1, 32'h8765_4321, 1'b0);
      add_request(dssb_pkg::OP_POP,  1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_POP,  1'b0, '0, 1'b0);
      add_request(dssb_pkg::OP_POP,  1'b1, '0, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b1, 32'hcafe_f00d, 1'b0);
      add_request(dssb_pkg::OP_PUSH, 1'b0, 32'h0bad_beef, 1'b0);
      add_request(dssb_pkg::OP_SHOW, 1'b1, '0, 1'b0);
      wait_until_drained();

      // Above the depth the capacity is clipped; mostly pushes to fill deep.
      write_capacity('1);
      add_random_requests(90, 60, 20);
      wait_until_drained();

      sender_idle_pct = 82;
      write_capacity(7'd5);
      add_random_requests(100, 35, 40);
      wait_until_drained();

      sender_idle_pct = 0;
      write_capacity(7'd64);
      add_random_requests(100, 45, 30);
      wait_until_drained();
      repeat (20) @(posedge clock);

      $display("Checked %0d results from %0d requests at capacities 64, 0, 127, 5, 64.",
               results_checked, requests_taken);
      $display("Overflows %0d, underflows %0d, empty shows %0d, deepest show %0d entries.",
               overflows, underflows, empty_shows, deepest_show);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/dssb_pkg.sv
src/dssb_front.sv
src/dssb_back.sv
src/dual_stack_shared_buffer_core.sv
tb/sv/tb.sv
